### sv/vgld_pkg.sv
// Shared types and constants for the vector glyph line decoder.
`timescale 1ns / 1ps
`default_nettype none

package vgld_pkg;

    localparam int GLYPH_W  = 17;
    localparam int COUNT_W  = 10;
    localparam int POS_W    = 11;
    localparam int COORD_W  = 9;
    localparam int BASE_W   = 5;
    localparam int OUT_DATA_W = 48;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_R       = 8'h52;
    localparam logic signed [COORD_W-1:0] VAL_OFFSET = 9'sd82;
    localparam logic [BASE_W-1:0] BASELINE_RESET = 5'd9;

    // Register map (byte addresses)
    localparam logic [2:0] ADDR_BASELINE = 3'd0;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_VERTEX   = 2'd1,
        KIND_PATH_END = 2'd2,
        KIND_STATUS   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_SHORT     = 2'd1,
        STAT_MISMATCH  = 2'd2,
        STAT_EDGE_BAD  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                      kind;
        logic [GLYPH_W-1:0]         glyph_number;
        logic signed [COORD_W-1:0]  advance_width;
        logic signed [COORD_W-1:0]  vertex_x;
        logic signed [COORD_W-1:0]  vertex_y;
        status_t                    line_status;
        logic                       final_result;
    } result_t;

endpackage

`default_nettype wire

### sv/vector_glyph_line_decoder_unit.sv
// Top level: glyph record line decoder with result queue and APB register port.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one text line of a vector-font glyph record, one byte per request.
// Input stream: s_axis_tdata carries the character, s_axis_tlast marks the
// last byte of the line (a newline carrying tlast is dropped).
// Output stream: one request per result. tuser is the result kind (header,
// vertex, path end, line status); tlast marks the status, which is the last
// result of a line. Vertices go out before the status is known, so a consumer
// drops the whole line when the status is not ok.
// Each accepted byte is decoded in the cycle it is taken; its results sit in a
// three-entry result queue and the first is offered on the next cycle. A byte
// gives at most one result, except the end-of-line byte, which gives up to
// three. The block takes one byte per cycle as long as each byte gives at
// most one result and the receiver keeps up; after an end-of-line byte input
// is held off until the queue is down to its last entry. A receiver stall
// holds the queue contents and, once the queue holds more than one entry or
// one entry not being taken, holds off input. Reset empties the queue, clears
// all per-line state and sets baseline_offset (byte address 0) to 9.
// Configuration must be written only while idle; the block does not check.
module vector_glyph_line_decoder_unit #(
    parameter int NUMBER_DIGITS = 5,
    parameter int COUNT_DIGITS  = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tlast,   // end_of_line
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [16:0] glyph_number, [25:17] advance_width, [34:26] vertex_x,
    // [43:35] vertex_y, [45:44] line_status, [47:46] zero
    output logic [vgld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast    // final_result
);
    import vgld_pkg::*;

    // Field boundaries, counted in bytes from the start of the line.
    localparam logic [POS_W-1:0] HDR_LEN   = POS_W'(NUMBER_DIGITS + COUNT_DIGITS);
    localparam logic [POS_W-1:0] NUM_END   = POS_W'(NUMBER_DIGITS);
    localparam logic [POS_W-1:0] RIGHT_POS = POS_W'(NUMBER_DIGITS + COUNT_DIGITS + 1);
    localparam logic [POS_W-1:0] MIN_LEN   = POS_W'(NUMBER_DIGITS + COUNT_DIGITS + 2);
    localparam logic [POS_W-1:0] PAIR1_POS = POS_W'(NUMBER_DIGITS + COUNT_DIGITS + 4);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [BASE_W-1:0] baseline_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BASELINE);
    assign prdata    = (paddr == ADDR_BASELINE) ? {{(32-BASE_W){1'b0}}, baseline_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= BASELINE_RESET;
        end
        else if (cfg_write)
        begin
            baseline_reg <= pwdata[BASE_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Per-line state
    // ---------------------------------------------------------------
    logic [POS_W-1:0]          pos_reg,         pos_next;
    logic [GLYPH_W-1:0]        glyph_reg,       glyph_next;
    logic                      glyph_done_reg,  glyph_done_next;
    logic                      glyph_start_reg, glyph_start_next;
    logic [COUNT_W-1:0]        count_reg,       count_next;
    logic                      count_done_reg,  count_done_next;
    logic                      count_start_reg, count_start_next;
    logic signed [COORD_W-1:0] left_reg,        left_next;
    logic                      edge_bad_reg,    edge_bad_next;
    logic [7:0]                held_reg,        held_next;

    // ---------------------------------------------------------------
    // Result queue: slot 0 is the one on the output
    // ---------------------------------------------------------------
    result_t    res_reg [3];
    result_t    res_next [3];
    logic [1:0] cnt_reg, cnt_next;

    logic       push, pop;
    logic [7:0] b;
    logic       eol;
    logic       take_byte;
    logic       is_digit;
    logic       pair_odd;

    logic signed [COORD_W-1:0] right_val;
    logic signed [COORD_W-1:0] held_val;
    logic [COORD_W:0]          vy_wide;
    logic [POS_W-1:0]          pair_len;

    result_t    data_res;
    logic       data_valid;
    logic       pend_valid;
    status_t    stat;
    result_t    gen [3];
    logic [1:0] gen_cnt;

    assign b   = s_axis_tdata;
    assign eol = s_axis_tlast;

    assign pop           = (cnt_reg != 2'd0) && m_axis_tready;
    assign s_axis_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign push          = s_axis_tvalid && s_axis_tready;

    assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign take_byte = !(eol && (b == CHAR_NEWLINE)) && (pos_reg != POS_MAX);
    assign pair_odd  = pos_reg[0] ^ HDR_LEN[0];

    assign right_val = $signed({1'b0, b}) - VAL_OFFSET;
    assign held_val  = $signed({1'b0, held_reg}) - VAL_OFFSET;
    // baseline + 'R' - raw byte; fits in the 9-bit field
    assign vy_wide   = {{(COORD_W+1-BASE_W){1'b0}}, baseline_reg} + {2'b00, CHAR_R}
                       - {2'b00, b};

    // Decode one byte: state update and the result it causes.
    always_comb
    begin
        pos_next         = pos_reg;
        glyph_next       = glyph_reg;
        glyph_done_next  = glyph_done_reg;
        glyph_start_next = glyph_start_reg;
        count_next       = count_reg;
        count_done_next  = count_done_reg;
        count_start_next = count_start_reg;
        left_next        = left_reg;
        edge_bad_next    = edge_bad_reg;
        held_next        = held_reg;
        data_valid       = 1'b0;

        if (take_byte)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < NUM_END)
            begin
                if (!glyph_done_reg && !(!glyph_start_reg && (b == CHAR_SPACE)))
                begin
                    if (is_digit)
                    begin
                        glyph_next = GLYPH_W'((glyph_reg << 3) + (glyph_reg << 1)
                                              + {{(GLYPH_W-4){1'b0}}, b[3:0]});
                        glyph_start_next = 1'b1;
                    end
                    else
                    begin
                        glyph_done_next = 1'b1;
                    end
                end
            end
            else if (pos_reg < HDR_LEN)
            begin
                if (!count_done_reg && !(!count_start_reg && (b == CHAR_SPACE)))
                begin
                    if (is_digit)
                    begin
                        count_next = COUNT_W'((count_reg << 3) + (count_reg << 1)
                                              + {{(COUNT_W-4){1'b0}}, b[3:0]});
                        count_start_next = 1'b1;
                    end
                    else
                    begin
                        count_done_next = 1'b1;
                    end
                end
            end
            else if (pos_reg == HDR_LEN)
            begin
                left_next = right_val;
            end
            else if (pos_reg == RIGHT_POS)
            begin
                edge_bad_next = left_reg > right_val;
                data_valid    = 1'b1;
            end
            else if (!pair_odd)
            begin
                held_next = b;
            end
            else
            begin
                data_valid = 1'b1;
            end
        end

        // data result: header, vertex or path end
        data_res              = '0;
        data_res.glyph_number = glyph_next;
        if (pos_reg == RIGHT_POS)
        begin
            data_res.kind          = KIND_HEADER;
            data_res.advance_width = right_val - left_reg;
        end
        else if ((pos_reg >= PAIR1_POS) && (held_reg == CHAR_SPACE) && (b == CHAR_R))
        begin
            data_res.kind = KIND_PATH_END;
        end
        else
        begin
            data_res.kind     = KIND_VERTEX;
            data_res.vertex_x = held_val - left_reg;
            data_res.vertex_y = $signed(vy_wide[COORD_W-1:0]);
        end

        // line status, priority: too short, length mismatch, edge order
        pair_len = pos_next - HDR_LEN;
        if (pos_next < MIN_LEN)
        begin
            stat = STAT_SHORT;
        end
        else if ({count_next, 1'b0} != pair_len)
        begin
            stat = STAT_MISMATCH;
        end
        else if (edge_bad_next)
        begin
            stat = STAT_EDGE_BAD;
        end
        else
        begin
            stat = STAT_OK;
        end
        pend_valid = eol && (stat == STAT_OK) && (pos_next >= PAIR1_POS);

        // pack results in order
        gen[0]  = data_res;
        gen[1]  = '0;
        gen[2]  = '0;
        gen_cnt = 2'd0;
        if (data_valid)
        begin
            gen_cnt = 2'd1;
        end
        if (pend_valid)
        begin
            gen[gen_cnt]              = '0;
            gen[gen_cnt].kind         = KIND_PATH_END;
            gen[gen_cnt].glyph_number = glyph_next;
            gen_cnt                   = gen_cnt + 2'd1;
        end
        if (eol)
        begin
            gen[gen_cnt]              = '0;
            gen[gen_cnt].kind         = KIND_STATUS;
            gen[gen_cnt].glyph_number = glyph_next;
            gen[gen_cnt].line_status  = stat;
            gen[gen_cnt].final_result = 1'b1;
            gen_cnt                   = gen_cnt + 2'd1;
        end

        // end of line returns all line state to zero
        if (eol)
        begin
            pos_next         = '0;
            glyph_next       = '0;
            glyph_done_next  = 1'b0;
            glyph_start_next = 1'b0;
            count_next       = '0;
            count_done_next  = 1'b0;
            count_start_next = 1'b0;
            left_next        = '0;
            edge_bad_next    = 1'b0;
            held_next        = '0;
        end
    end

    // Queue update: a push only happens when the queue is empty or drains this cycle.
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            res_next = gen;
            cnt_next = gen_cnt;
        end
        else if (pop)
        begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= 2'd0;
            pos_reg         <= '0;
            glyph_reg       <= '0;
            glyph_done_reg  <= 1'b0;
            glyph_start_reg <= 1'b0;
            count_reg       <= '0;
            count_done_reg  <= 1'b0;
            count_start_reg <= 1'b0;
            left_reg        <= '0;
            edge_bad_reg    <= 1'b0;
            held_reg        <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                pos_reg         <= pos_next;
                glyph_reg       <= glyph_next;
                glyph_done_reg  <= glyph_done_next;
                glyph_start_reg <= glyph_start_next;
                count_reg       <= count_next;
                count_done_reg  <= count_done_next;
                count_start_reg <= count_start_next;
                left_reg        <= left_next;
                edge_bad_reg    <= edge_bad_next;
                held_reg        <= held_next;
            end
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // ---------------------------------------------------------------
    // Output stream
    // ---------------------------------------------------------------
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tuser  = res_reg[0].kind;
    assign m_axis_tlast  = res_reg[0].final_result;
    assign m_axis_tdata  = {2'b00,
                            res_reg[0].line_status,
                            res_reg[0].vertex_y,
                            res_reg[0].vertex_x,
                            res_reg[0].advance_width,
                            res_reg[0].glyph_number};

endmodule

`default_nettype wire

### test/tb_vector_glyph_line_decoder_unit.sv
// Testbench for the vector glyph line decoder: random record lines, predicted results, checks.
`timescale 1ns / 1ps

import vgld_pkg::*;

localparam int GLYPH_DIGITS = 5;
localparam int COUNT_DIGITS = 3;

// Follows the decoder line state, predicts results per accepted byte, checks results.
class glyph_result_tracker;
    localparam int FIELDS_LEN = GLYPH_DIGITS + COUNT_DIGITS;
    localparam int R_OFFSET   = int'(CHAR_R);
    localparam int PRINT_CAP  = 50;

    logic [BASE_W-1:0] baseline;
    int      line_pos;
    int      glyph_acc;
    bit      glyph_done;
    bit      glyph_seen;
    int      count_acc;
    bit      count_done;
    bit      count_seen;
    int      left_edge;
    bit      edges_swapped;
    int      held_byte;
    result_t pending_results[$];
    int      errors;
    int      checked;
    int      lines;

    function new();
        baseline = BASELINE_RESET;
        errors   = 0;
        checked  = 0;
        lines    = 0;
        clear_line();
    endfunction

    function void clear_line();
        line_pos      = 0;
        glyph_acc     = 0;
        glyph_done    = 0;
        glyph_seen    = 0;
        count_acc     = 0;
        count_done    = 0;
        count_seen    = 0;
        left_edge     = 0;
        edges_swapped = 0;
        held_byte     = 0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Leading spaces are skipped; any other non-digit closes the field.
    function void take_digit(input int c, inout int acc, inout bit done, inout bit seen,
                             input int mask);
        if (done || (!seen && c == int'(CHAR_SPACE)))
            return;
        if (c >= int'(CHAR_ZERO) && c <= int'(CHAR_NINE))
        begin
            acc  = (acc * 10 + c - int'(CHAR_ZERO)) & mask;
            seen = 1'b1;
        end
        else
            done = 1'b1;
    endfunction

    function void add_result(kind_t k, int adv, int vx, int vy, status_t st, bit fin);
        result_t r;
        r.kind          = k;
        r.glyph_number  = glyph_acc[GLYPH_W-1:0];
        r.advance_width = adv[COORD_W-1:0];
        r.vertex_x      = vx[COORD_W-1:0];
        r.vertex_y      = vy[COORD_W-1:0];
        r.line_status   = st;
        r.final_result  = fin;
        pending_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, bit eol);
        int      c;
        int      p;
        int      right;
        int      pair_idx;
        status_t st;
        c = int'(b);
        // a newline carrying end of line is dropped; the position counter saturates
        if (!(eol && b == CHAR_NEWLINE) && line_pos < int'(POS_MAX))
        begin
            p = line_pos;
            line_pos++;
            if (p < GLYPH_DIGITS)
                take_digit(c, glyph_acc, glyph_done, glyph_seen, 'h1FFFF);
            else if (p < FIELDS_LEN)
                take_digit(c, count_acc, count_done, count_seen, 'h3FF);
            else if (p == FIELDS_LEN)
                left_edge = c - R_OFFSET;
            else if (p == FIELDS_LEN + 1)
            begin
                right         = c - R_OFFSET;
                edges_swapped = left_edge > right;
                add_result(KIND_HEADER, right - left_edge, 0, 0, STAT_OK, 1'b0);
            end
            else if (((p - FIELDS_LEN) % 2) == 0)
                held_byte = c;
            else
            begin
                pair_idx = (p - FIELDS_LEN) / 2 - 1;
                if (pair_idx >= 1 && held_byte == int'(CHAR_SPACE) && c == R_OFFSET)
                    add_result(KIND_PATH_END, 0, 0, 0, STAT_OK, 1'b0);
                else
                    add_result(KIND_VERTEX, 0, held_byte - R_OFFSET - left_edge,
                               int'(baseline) - (c - R_OFFSET), STAT_OK, 1'b0);
            end
        end
        if (eol)
        begin
            // the pair count also covers the edge pair
            if (line_pos < FIELDS_LEN + 2)
                st = STAT_SHORT;
            else if (count_acc * 2 != line_pos - FIELDS_LEN)
                st = STAT_MISMATCH;
            else if (edges_swapped)
                st = STAT_EDGE_BAD;
            else
                st = STAT_OK;
            if (st == STAT_OK && line_pos >= FIELDS_LEN + 4)
                add_result(KIND_PATH_END, 0, 0, 0, STAT_OK, 1'b0);
            add_result(KIND_STATUS, 0, 0, 0, st, 1'b1);
            clear_line();
            lines++;
        end
    endfunction

    task report(string msg);
        if (errors < PRINT_CAP)
            $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
        if (got_v !== want_v)
            report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             checked, name, got_v, want_v));
    endtask

    task check_result(result_t got);
        result_t want;
        checked++;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result %0d of kind %0d arrived with none outstanding",
                             checked, got.kind));
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", 32'(got.kind), 32'(want.kind));
        compare_field("glyph_number", 32'(got.glyph_number), 32'(want.glyph_number));
        compare_field("advance_width", 32'(got.advance_width), 32'(want.advance_width));
        compare_field("vertex_x", 32'(got.vertex_x), 32'(want.vertex_x));
        compare_field("vertex_y", 32'(got.vertex_y), 32'(want.vertex_y));
        compare_field("line_status", 32'(got.line_status), 32'(want.line_status));
        compare_field("final_result", 32'(got.final_result), 32'(want.final_result));
    endtask
endclass

module tb_vector_glyph_line_decoder_unit;

    // no transfer on either stream for this many cycles ends the run
    localparam int STALL_LIMIT = 1000;
    // random bytes per baseline setting
    localparam int PHASE_BYTES = 50;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] char_byte
    logic        s_axis_tlast  = 1'b0;  // end_of_line
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [16:0] glyph_number, [25:17] advance_width, [34:26] vertex_x,
    // [43:35] vertex_y, [45:44] line_status, [47:46] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;          // final_result

    glyph_result_tracker tracker;
    logic [7:0] line_buf[$];            // bytes of the line being built
    bit         src_steady  = 1'b0;     // sender never idles
    bit         sink_steady = 1'b0;     // receiver never stalls
    int         bytes_sent  = 0;
    int         idle_cycles = 0;
    result_t    seen;

    vector_glyph_line_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 2 ns clock
    always
    begin
        #1 clk = ~clk;
    end

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    // Mostly near the 'R' origin, now and then any byte value.
    function automatic logic [7:0] coord_char();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(int'(CHAR_R) - 25, int'(CHAR_R) + 25));
    endfunction

    // ---------------------------------------------------------------
    // Line building
    // ---------------------------------------------------------------

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Decimal field, leading zeros padded with spaces or kept; now and then one
    // character is replaced by a sign, tab or letter, which closes the field.
    task automatic put_field(input int value, input int width);
        logic [7:0] chars[GLYPH_DIGITS];
        logic [7:0] pad;
        int         v;
        bit         lead;
        v    = value;
        pad  = $urandom_range(0, 1) ? CHAR_SPACE : CHAR_ZERO;
        lead = 1'b1;
        for (int i = width - 1; i >= 0; i--)
        begin
            chars[i] = CHAR_ZERO + 8'(v % 10);
            v        = v / 10;
        end
        for (int i = 0; i < width - 1; i++)
        begin
            if (lead && chars[i] == CHAR_ZERO)
                chars[i] = pad;
            else
                lead = 1'b0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       chars[$urandom_range(0, width - 1)] = "+";
                1:       chars[$urandom_range(0, width - 1)] = "-";
                2:       chars[$urandom_range(0, width - 1)] = 8'h09;
                default: chars[$urandom_range(0, width - 1)] = "x";
            endcase
        end
        for (int i = 0; i < width; i++)
            line_buf.push_back(chars[i]);
    endtask

    // Glyph record: number, pair count, edges, pairs with some pen-ups.
    task automatic build_glyph_line(input bit count_matches);
        int         pairs;
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] tmp;
        pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
        put_field($urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(0, 99999),
                  GLYPH_DIGITS);
        // the stored count includes the edge pair
        put_field(count_matches ? pairs + 1 : $urandom_range(0, 999), COUNT_DIGITS);
        left  = coord_char();
        right = coord_char();
        // about one line in seven gets its edges in the wrong order
        if ((left > right) != ($urandom_range(0, 6) == 0))
        begin
            tmp   = left;
            left  = right;
            right = tmp;
        end
        line_buf.push_back(left);
        line_buf.push_back(right);
        for (int i = 0; i < pairs; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                line_buf.push_back(CHAR_SPACE);
                line_buf.push_back(CHAR_R);
            end
            else
            begin
                line_buf.push_back(coord_char());
                line_buf.push_back(coord_char());
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Stream drivers
    // ---------------------------------------------------------------

    // Called at a rising edge; returns at the edge where the byte is taken.
    task automatic send_byte(input logic [7:0] b, input bit eol);
        int gap;
        gap = draw_gap(src_steady);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eol;
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_byte(b, eol);
        bytes_sent++;
    endtask

    // Sends the built line; end of line rides on the last byte or on an added newline.
    task automatic send_line(input bit add_newline);
        if (add_newline || line_buf.size() == 0)
            line_buf.push_back(CHAR_NEWLINE);
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // Drop valid and wait until every predicted result has come out, plus a margin.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_baseline();
        logic [31:0] rd;
        apb_read(ADDR_BASELINE, rd);
        if (rd !== {27'b0, tracker.baseline})
            tracker.report($sformatf("baseline_offset reads 0x%0h, expected 0x%0h",
                                     rd, tracker.baseline));
    endtask

    task automatic write_baseline(input logic [BASE_W-1:0] value);
        apb_write(ADDR_BASELINE, {27'b0, value});
        tracker.baseline = value;
        verify_baseline();
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls, one draw per result
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(sink_steady);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Result monitor and watchdog. Both sample the pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.kind          = kind_t'(m_axis_tuser);
                seen.glyph_number  = m_axis_tdata[16:0];
                seen.advance_width = m_axis_tdata[25:17];
                seen.vertex_x      = m_axis_tdata[34:26];
                seen.vertex_y      = m_axis_tdata[43:35];
                seen.line_status   = status_t'(m_axis_tdata[45:44]);
                seen.final_result  = m_axis_tlast;
                tracker.check_result(seen);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, tracker.pending());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int target;
        int sel;
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        verify_baseline();

        // Directed lines at the reset baseline.
        // Empty line: a lone dropped newline is too short.
        send_line(1'b1);
        // Largest glyph number, edges in the wrong order, count exactly right.
        put_text("99999  1ZA");
        send_line(1'b0);
        // Tab closes the glyph field; edges at byte extremes 0 and 255; a pen-up
        // pair first (a vertex), then a real pen-up; trailing newline dropped.
        put_text(" 4\t99  3");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        put_text(" R R");
        send_line(1'b1);

        // Random phases, each under its own baseline and idling mix.
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1:       write_baseline('0);
                    2:       write_baseline('1);
                    default: write_baseline(BASE_W'($urandom_range(0, 31)));
                endcase
            end
            src_steady  = (phase == 1 || phase == 3);
            sink_steady = (phase == 2 || phase == 3);
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    build_glyph_line(1'b1);
                else if (sel < 72)
                    build_glyph_line(1'b0);
                else if (sel < 84)
                begin
                    // too short: digits, spaces or anything
                    repeat ($urandom_range(0, 9))
                        line_buf.push_back($urandom_range(0, 1) ?
                            8'($urandom_range(int'(CHAR_SPACE), int'(CHAR_NINE))) :
                            8'($urandom_range(0, 255)));
                end
                else
                begin
                    repeat ($urandom_range(1, 30))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end
                send_line(1'($urandom_range(0, 1)));
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes in %0d lines: glyph records, bad counts, short, noise;",
                 bytes_sent, tracker.lines);
        $display("%0d results checked at five baseline settings", tracker.checked);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
sv/vgld_pkg.sv
sv/vector_glyph_line_decoder_unit.sv
test/tb_vector_glyph_line_decoder_unit.sv
